/* sv/fcw_pkg.sv */
// ----------------------------------------------------------------------------
// fcw_pkg
// Shared types and constants for the FAT12 cluster chain walker.
// ----------------------------------------------------------------------------
`default_nettype none

package fcw_pkg;

    localparam int unsigned CLUSTER_W   = 12;
    localparam int unsigned ADDR_W      = 13;
    localparam int unsigned LBA_W       = 32;
    localparam int unsigned SPC_W       = 8;

    localparam logic [CLUSTER_W-1:0] END_MARK     = 12'hFF8;
    localparam logic [ADDR_W-1:0]    CLUSTER_BIAS = 13'd2;

    // register addresses, byte offsets on the config port
    localparam logic [2:0] REG_DATA_START = 3'd0;
    localparam logic [2:0] REG_SPC        = 3'd4;

    localparam logic [LBA_W-1:0] DATA_START_RST = 32'd0;
    localparam logic [SPC_W-1:0] SPC_RST        = 8'd1;

    typedef enum logic [1:0] {
        ACT_LOAD    = 2'd0,
        ACT_START   = 2'd1,
        ACT_ADVANCE = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD_LO,
        ST_RD_HI,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [LBA_W-1:0] data_start_lba;
        logic [SPC_W-1:0] sectors_per_cluster;
    } cfg_t;

    typedef struct packed {
        logic wr_en;       // write table byte from input word
        logic take_start;  // current <= start_cluster
        logic take_next;   // current <= stored next cluster
        logic rd_en;       // table read
        logic rd_hi;       // read second byte of the entry
        logic mul_en;      // register sector offset product
        logic lo_en;       // capture first byte
        logic out_load;    // load result word
    } cmd_t;

    typedef struct packed {
        action_t action;
        logic    chain_ended;
        logic    out_busy;
    } stat_t;

endpackage

`default_nettype wire

/* sv/fcw_cfg.sv */
// ----------------------------------------------------------------------------
// fcw_cfg
// APB register file: data start sector and sectors per cluster.
// ----------------------------------------------------------------------------
`default_nettype none

module fcw_cfg
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic      [31:0]          prdata,
    output logic                      pready,
    output fcw_pkg::cfg_t             cfg
);

    logic [31:0] data_start_reg;
    logic [7:0]  spc_reg;
    logic        wr;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_start_reg <= fcw_pkg::DATA_START_RST;
            spc_reg        <= fcw_pkg::SPC_RST;
        end
        else if (wr)
        begin
            if (paddr[2] == fcw_pkg::REG_SPC[2])
                spc_reg <= pwdata[7:0];
            else
                data_start_reg <= pwdata;
        end
    end

    always_comb
    begin
        if (paddr[2] == fcw_pkg::REG_SPC[2])
            prdata = {24'd0, spc_reg};
        else
            prdata = data_start_reg;
    end

    assign cfg.data_start_lba      = data_start_reg;
    assign cfg.sectors_per_cluster = spc_reg;

endmodule

`default_nettype wire

/* sv/fcw_ctrl.sv */
// ----------------------------------------------------------------------------
// fcw_ctrl
// Sequencer: accepts words, steps the two table reads, hands off results.
// ----------------------------------------------------------------------------
`default_nettype none

module fcw_ctrl
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire fcw_pkg::stat_t stat,
    output fcw_pkg::cmd_t       cmd
);

    fcw_pkg::state_t state_reg;
    fcw_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= fcw_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            fcw_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    case (stat.action)
                        fcw_pkg::ACT_LOAD:
                            cmd.wr_en = 1'b1;
                        fcw_pkg::ACT_START:
                        begin
                            cmd.take_start = 1'b1;
                            state_next     = fcw_pkg::ST_RD_LO;
                        end
                        fcw_pkg::ACT_ADVANCE:
                        begin
                            if (!stat.chain_ended)
                            begin
                                cmd.take_next = 1'b1;
                                state_next    = fcw_pkg::ST_RD_LO;
                            end
                        end
                        default:
                            state_next = fcw_pkg::ST_IDLE;
                    endcase
                end
            end
            fcw_pkg::ST_RD_LO:
            begin
                cmd.rd_en  = 1'b1;
                cmd.mul_en = 1'b1;
                state_next = fcw_pkg::ST_RD_HI;
            end
            fcw_pkg::ST_RD_HI:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_hi  = 1'b1;
                cmd.lo_en  = 1'b1;
                state_next = fcw_pkg::ST_DONE;
            end
            fcw_pkg::ST_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = fcw_pkg::ST_IDLE;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

/* sv/fcw_dp.sv */
// ----------------------------------------------------------------------------
// fcw_dp
// Datapath: table memory, chain registers, sector math, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fcw_dp
#(
    parameter int TABLE_BYTES = 8192
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire fcw_pkg::cfg_t  cfg,
    input  wire fcw_pkg::cmd_t  cmd,
    output fcw_pkg::stat_t      stat,
    input  wire logic [1:0]     s_tuser,
    input  wire logic [39:0]    s_tdata,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [55:0]         m_tdata,   // cluster, sector_address, next_cluster
    output logic                m_tlast
);

    localparam int AW = $clog2(TABLE_BYTES);

    logic [7:0]    table_mem [TABLE_BYTES];

    logic [12:0]   load_addr;
    logic [7:0]    load_byte;
    logic [11:0]   start_cluster;

    logic [11:0]   cur_reg;
    logic          ended_reg;
    logic [7:0]    rdata_reg;
    logic [7:0]    lo_reg;
    logic [7:0]    hi_reg;
    logic [31:0]   prod_reg;
    logic          m_tvalid_reg;
    logic [11:0]   out_cluster_reg;
    logic [31:0]   out_lba_reg;
    logic [11:0]   out_next_reg;
    logic          out_last_reg;

    logic [13:0]   triple;
    logic [12:0]   ent_addr;
    logic [12:0]   rd_addr;
    logic [AW-1:0] mem_addr;
    logic          mem_we;
    logic [12:0]   diff;
    logic [39:0]   prod_full;
    logic [15:0]   word;
    logic [11:0]   entry;
    logic          entry_last;
    logic [15:0]   held_word;
    logic [11:0]   held_entry;

    assign load_addr     = s_tdata[12:0];
    assign load_byte     = s_tdata[20:13];
    assign start_cluster = s_tdata[32:21];

    // byte offset of the entry: cluster * 3 / 2
    assign triple   = {2'd0, cur_reg} + {1'b0, cur_reg, 1'b0};
    assign ent_addr = triple[13:1];
    assign rd_addr  = ent_addr + {12'd0, cmd.rd_hi};
    assign mem_we   = cmd.wr_en && (32'(load_addr) < 32'(TABLE_BYTES));
    assign mem_addr = cmd.wr_en ? AW'(load_addr) : AW'(rd_addr);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            table_mem[mem_addr] <= load_byte;
        if (cmd.rd_en)
            rdata_reg <= table_mem[mem_addr];
    end

    assign diff      = {1'b0, cur_reg} - fcw_pkg::CLUSTER_BIAS;
    assign prod_full = {{19{diff[12]}}, diff} * cfg.sectors_per_cluster;

    assign word       = {rdata_reg, lo_reg};
    assign entry      = cur_reg[0] ? word[15:4] : word[11:0];
    assign entry_last = (entry >= fcw_pkg::END_MARK);

    // entry bytes of the current cluster, kept in step with later loads
    assign held_word  = {hi_reg, lo_reg};
    assign held_entry = cur_reg[0] ? held_word[15:4] : held_word[11:0];

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
            prod_reg <= prod_full[31:0];
        if (cmd.lo_en)
            lo_reg <= rdata_reg;
        else if (mem_we && (load_addr == ent_addr))
            lo_reg <= load_byte;
        if (cmd.out_load)
            hi_reg <= rdata_reg;
        else if (mem_we && (load_addr == ent_addr + 13'd1))
            hi_reg <= load_byte;
        if (cmd.out_load)
        begin
            out_cluster_reg <= cur_reg;
            out_lba_reg     <= cfg.data_start_lba + prod_reg;
            out_next_reg    <= entry;
            out_last_reg    <= entry_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg      <= '0;
            ended_reg    <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.take_start)
                cur_reg <= start_cluster;
            else if (cmd.take_next)
                cur_reg <= held_entry;
            if (cmd.out_load)
            begin
                ended_reg    <= entry_last;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    assign stat.action      = fcw_pkg::action_t'(s_tuser);
    assign stat.chain_ended = ended_reg;
    assign stat.out_busy    = m_tvalid_reg & ~m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_next_reg, out_lba_reg, out_cluster_reg};
    assign m_tlast  = out_last_reg;

    a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> !cmd.wr_en)
        else $error("table read and write in the same cycle");

    a_hi_after_lo: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rd_en && cmd.rd_hi) |-> ($past(cmd.rd_en) && !$past(cmd.rd_hi)))
        else $error("second table byte read without first");

    a_no_adv_end: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take_next |-> !ended_reg)
        else $error("advance taken after end of chain");

    a_last_state: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> (m_tlast == ended_reg) && m_tvalid)
        else $error("last flag and chain end state disagree");

endmodule

`default_nettype wire

/* sv/fat12_cluster_chain_walker.sv */
// ----------------------------------------------------------------------------
// fat12_cluster_chain_walker
// Holds a FAT12 allocation table and follows a file's cluster chain.
// ----------------------------------------------------------------------------
// channel   dir  handshake          contents
// s_*       in   tvalid/tready      tuser: action; tdata: address, byte, start
// m_*       out  tvalid/tready      tdata: cluster, sector, next; tlast: end
// apb       in   psel/penable       data start sector, sectors per cluster
//
// A load word is written to the table when accepted. A start or advance
// reads the entry's first byte while registering the sector offset, then
// its second byte, then loads the result: the two bytes come from one
// single-port table memory, one read per cycle. A waiting result holds the
// sequencer in its last step only until the result register is free.
// Reset clears control state; table contents are undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module fat12_cluster_chain_walker
#(
    parameter int TABLE_BYTES = 8192
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [1:0]  s_tuser,   // [1:0] action
    input  wire logic [39:0] s_tdata,   // [12:0] table_address, [20:13] table_byte,
                                        // [32:21] start_cluster, rest zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // [11:0] cluster, [43:12] sector_address,
                                        // [55:44] next_cluster
    output logic             m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    fcw_pkg::cfg_t  cfg;
    fcw_pkg::cmd_t  cmd;
    fcw_pkg::stat_t stat;

    fcw_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fcw_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fcw_dp #(
        .TABLE_BYTES (TABLE_BYTES)
    ) u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cmd      (cmd),
        .stat     (stat),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
